// File: hdl/cgmd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_pkg
// Shared constants and types of the consumer group message dispatcher.
// ---------------------------------------------------------------------------
package cgmd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_GROUPS_DEF  = 8;
  localparam int GROUP_SIZE_DEF  = 2;

  localparam logic [1:0] CMD_PUBLISH  = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FULL         = 3'd1;
  localparam logic [2:0] ST_EMPTY        = 3'd2;
  localparam logic [2:0] ST_GROUPS_FULL  = 3'd3;
  localparam logic [2:0] ST_NO_CONSUMERS = 3'd4;

  typedef enum logic [2:0] {
    RES_PUB      = 3'd0,
    RES_REG      = 3'd1,
    RES_EMPTY    = 3'd2,
    RES_NOCONS   = 3'd3,
    RES_DISPATCH = 3'd4
  } res_sel_e;

  typedef struct packed {
    logic     ld_in;
    logic     pub_do;
    logic     reg_do;
    logic     pop_do;
    logic     grp_load;
    logic     grp_dec;
    logic     ptr_latch;
    logic     emit;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       fifo_empty;
    logic       no_groups;
    logic       last_group;
    logic       out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: hdl/cgmd_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_in_if
// Command channel: valid/ready handshake with the command word.
// ---------------------------------------------------------------------------
interface cgmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] payload_ref;
  logic [15:0] consumer_handle;

  modport source (output valid, command, payload_ref, consumer_handle, input ready);
  modport sink   (input valid, command, payload_ref, consumer_handle, output ready);
endinterface
`default_nettype wire

// File: hdl/cgmd_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_out_if
// Result channel: valid/ready handshake with the result word.
// ---------------------------------------------------------------------------
interface cgmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  group_id;
  logic        member_index;
  logic [15:0] target_handle;
  logic [31:0] message_id;
  logic [31:0] message_ref;
  logic        last;

  modport source (output valid, status, group_id, member_index, target_handle,
                  message_id, message_ref, last, input ready);
  modport sink   (input valid, status, group_id, member_index, target_handle,
                  message_id, message_ref, last, output ready);
endinterface
`default_nettype wire

// File: hdl/cgmd_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module cgmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/cgmd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_ctrl
// Command sequencer: decodes each command word and steps the datapath.
// ---------------------------------------------------------------------------
module cgmd_ctrl
  import cgmd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire ctrl_stat_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PUB    = 4'd2;
  localparam logic [3:0] S_REG    = 4'd3;
  localparam logic [3:0] S_EMPTY  = 4'd4;
  localparam logic [3:0] S_NOCONS = 4'd5;
  localparam logic [3:0] S_PTR    = 4'd6;
  localparam logic [3:0] S_HND    = 4'd7;
  localparam logic [3:0] S_DEMIT  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_sel  = RES_PUB;
    in_ready_o     = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_PUBLISH:  state_d = S_PUB;
          CMD_REGISTER: state_d = S_REG;
          CMD_DISPATCH: begin
            if (stat_i.fifo_empty) begin
              state_d = S_EMPTY;
            end else begin
              cmd_o.pop_do = 1'b1;
              if (stat_i.no_groups) begin
                state_d = S_NOCONS;
              end else begin
                cmd_o.grp_load = 1'b1;
                state_d        = S_PTR;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PUB: begin
        cmd_o.res_sel = RES_PUB;
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.pub_do = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_REG: begin
        cmd_o.res_sel = RES_REG;
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.reg_do = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd_o.res_sel = RES_EMPTY;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_NOCONS: begin
        cmd_o.res_sel = RES_NOCONS;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_PTR: state_d = S_HND;
      S_HND: begin
        cmd_o.ptr_latch = 1'b1;
        state_d         = S_DEMIT;
      end
      S_DEMIT: begin
        cmd_o.res_sel = RES_DISPATCH;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_group) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.grp_dec = 1'b1;
            state_d       = S_PTR;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cgmd_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cgmd_dpath
// Datapath: message ring, group bookkeeping, member tables, result register.
// ---------------------------------------------------------------------------
module cgmd_dpath
  import cgmd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
  parameter int GROUP_SIZE  = GROUP_SIZE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  output ctrl_stat_t       stat_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] payload_ref_i,
  input  wire logic [15:0] consumer_handle_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [2:0]       group_id_o,
  output logic             member_index_o,
  output logic [15:0]      target_handle_o,
  output logic [31:0]      message_id_o,
  output logic [31:0]      message_ref_o,
  output logic             last_o
);

  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int OCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int OW     = $clog2(MAX_GROUPS + 1);
  localparam int CW     = $clog2(GROUP_SIZE + 1);
  localparam int PW     = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int HDEPTH = MAX_GROUPS * GROUP_SIZE;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

  // latched command word
  logic [1:0]  cmd_q;
  logic [31:0] payload_q;
  logic [15:0] handle_q;

  // ring and group bookkeeping
  logic [QW-1:0]  head_q, tail_q;
  logic [OCW-1:0] occ_q;
  logic [31:0]    next_num_q;
  logic [OW-1:0]  groups_open_q;
  logic [CW-1:0]  newest_cnt_q;

  // dispatch walk
  logic [GW-1:0]  gi_q;
  logic [PW-1:0]  ptr_q;
  logic [31:0]    msg_id_q, msg_ref_q;

  // result register
  logic        out_valid_q;
  logic [2:0]  status_q, group_id_q;
  logic        member_q, last_q;
  logic [15:0] target_q;
  logic [31:0] id_q, ref_q;

  logic           fifo_full, out_free, can_join, groups_full, open_new, disp_emit;
  logic [GW-1:0]  gn;
  logic [QW-1:0]  head_nxt, tail_nxt;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic           h_we, p_we;
  logic [GW-1:0]  p_waddr;
  logic [PW-1:0]  p_wdata, ptr_rdata, ptr_next;
  logic [CW-1:0]  grp_cnt, ptr_inc;
  logic [31:0]    pay_rdata;
  logic [15:0]    hnd_rdata;

  logic [2:0]  res_status, res_group;
  logic        res_member, res_last;
  logic [15:0] res_target;
  logic [31:0] res_id, res_ref;

  assign fifo_full   = (occ_q == OCW'(QUEUE_DEPTH));
  assign out_free    = !out_valid_q || out_ready_i;
  assign gn          = GW'(groups_open_q - OW'(1));
  assign can_join    = (groups_open_q != '0) && (newest_cnt_q < CW'(GROUP_SIZE));
  assign groups_full = (groups_open_q == OW'(MAX_GROUPS));
  assign open_new    = !can_join && !groups_full;
  assign disp_emit   = cmd_i.emit && (cmd_i.res_sel == RES_DISPATCH);

  assign head_nxt = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
  assign tail_nxt = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);

  assign grp_cnt  = (gi_q == gn) ? newest_cnt_q : CW'(GROUP_SIZE);
  assign ptr_inc  = CW'(ptr_q) + CW'(1);
  assign ptr_next = (ptr_inc == grp_cnt) ? '0 : PW'(ptr_inc);

  assign stat_o.cmd        = cmd_q;
  assign stat_o.fifo_empty = (occ_q == '0);
  assign stat_o.no_groups  = (groups_open_q == '0);
  assign stat_o.last_group = (gi_q == '0);
  assign stat_o.out_free   = out_free;

  // member table writes on register, reads on dispatch
  always_comb begin
    h_we    = cmd_i.reg_do && (can_join || !groups_full);
    h_waddr = can_join ? (HAW'(gn) * HAW'(GROUP_SIZE) + HAW'(newest_cnt_q))
                       : HAW'(groups_open_q) * HAW'(GROUP_SIZE);
    h_raddr = HAW'(gi_q) * HAW'(GROUP_SIZE) + HAW'(ptr_rdata);
    p_we    = disp_emit || (cmd_i.reg_do && open_new);
    p_waddr = disp_emit ? gi_q : GW'(groups_open_q);
    p_wdata = disp_emit ? ptr_next : '0;
  end

  cgmd_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pub_do && !fifo_full),
    .waddr_i (tail_q),
    .wdata_i (payload_q),
    .re_i    (1'b1),
    .raddr_i (head_q),
    .rdata_o (pay_rdata)
  );

  cgmd_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_hnd_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (handle_q),
    .re_i    (cmd_i.ptr_latch),
    .raddr_i (h_raddr),
    .rdata_o (hnd_rdata)
  );

  cgmd_ram #(.WIDTH(PW), .DEPTH(MAX_GROUPS)) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (1'b1),
    .raddr_i (gi_q),
    .rdata_o (ptr_rdata)
  );

  always_comb begin
    res_status = ST_OK;
    res_group  = '0;
    res_member = 1'b0;
    res_target = '0;
    res_id     = '0;
    res_ref    = '0;
    res_last   = 1'b1;
    case (cmd_i.res_sel)
      RES_PUB: begin
        res_ref = payload_q;
        if (fifo_full) begin
          res_status = ST_FULL;
        end else begin
          res_id = next_num_q;
        end
      end
      RES_REG: begin
        if (can_join) begin
          res_group  = 3'(gn);
          res_member = 1'(newest_cnt_q);
          res_target = handle_q;
        end else if (groups_full) begin
          res_status = ST_GROUPS_FULL;
        end else begin
          res_group  = 3'(groups_open_q);
          res_target = handle_q;
        end
      end
      RES_EMPTY: res_status = ST_EMPTY;
      RES_NOCONS: begin
        res_status = ST_NO_CONSUMERS;
        res_id     = msg_id_q;
        res_ref    = msg_ref_q;
      end
      RES_DISPATCH: begin
        res_group  = 3'(gi_q);
        res_member = 1'(ptr_q);
        res_target = hnd_rdata;
        res_id     = msg_id_q;
        res_ref    = msg_ref_q;
        res_last   = (gi_q == '0);
      end
      default: res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      occ_q         <= '0;
      next_num_q    <= '0;
      groups_open_q <= '0;
      newest_cnt_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.pub_do && !fifo_full) begin
        tail_q     <= tail_nxt;
        occ_q      <= occ_q + OCW'(1);
        next_num_q <= next_num_q + 32'd1;
      end else if (cmd_i.pop_do) begin
        head_q <= head_nxt;
        occ_q  <= occ_q - OCW'(1);
      end
      if (cmd_i.reg_do) begin
        if (can_join) begin
          newest_cnt_q <= newest_cnt_q + CW'(1);
        end else if (!groups_full) begin
          groups_open_q <= groups_open_q + OW'(1);
          newest_cnt_q  <= CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      cmd_q     <= command_i;
      payload_q <= payload_ref_i;
      handle_q  <= consumer_handle_i;
    end
    if (cmd_i.pop_do) begin
      msg_id_q  <= next_num_q - 32'(occ_q);
      msg_ref_q <= pay_rdata;
    end
    if (cmd_i.grp_load) begin
      gi_q <= gn;
    end else if (cmd_i.grp_dec) begin
      gi_q <= gi_q - GW'(1);
    end
    if (cmd_i.ptr_latch) begin
      ptr_q <= ptr_rdata;
    end
    if (cmd_i.emit) begin
      status_q   <= res_status;
      group_id_q <= res_group;
      member_q   <= res_member;
      target_q   <= res_target;
      id_q       <= res_id;
      ref_q      <= res_ref;
      last_q     <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign group_id_o      = group_id_q;
  assign member_index_o  = member_q;
  assign target_handle_o = target_q;
  assign message_id_o    = id_q;
  assign message_ref_o   = ref_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCW'(QUEUE_DEPTH)) else $error("ring occupancy out of range");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == tail_q)) else $error("empty ring with head != tail");
  a_newest_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (groups_open_q != '0) |-> (newest_cnt_q != '0 && newest_cnt_q <= CW'(GROUP_SIZE)))
    else $error("newest group member count out of range");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result emitted into occupied register");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_do |-> (occ_q != '0)) else $error("pop from empty ring");
`endif

endmodule
`default_nettype wire

// File: hdl/consumer_group_message_dispatcher.sv
// ---------------------------------------------------------------------------
// consumer_group_message_dispatcher
// Publish, register, and dispatch on an empty ring or with no groups: decode,
// then the result is written to the result register. Dispatch with G open
// groups: decode, then per group a pointer RAM read, a member RAM read and the
// result, newest group first. Unknown command: decode, no result. A new command
// is taken only once the last one is done. A held result register stalls the
// sequencer. Async active-low reset clears ring pointers, counters and groups;
// RAM contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
module consumer_group_message_dispatcher
  import cgmd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
  parameter int GROUP_SIZE  = GROUP_SIZE_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cgmd_in_if.sink     in_ch_i,
  cgmd_out_if.source  out_ch_o
);

  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;
  logic       in_ready;

  assign in_ch_i.ready = in_ready;

  cgmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (ctrl_stat),
    .cmd_o      (ctrl_cmd)
  );

  cgmd_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_GROUPS  (MAX_GROUPS),
    .GROUP_SIZE  (GROUP_SIZE)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .stat_o            (ctrl_stat),
    .command_i         (in_ch_i.command),
    .payload_ref_i     (in_ch_i.payload_ref),
    .consumer_handle_i (in_ch_i.consumer_handle),
    .out_valid_o       (out_ch_o.valid),
    .out_ready_i       (out_ch_o.ready),
    .status_o          (out_ch_o.status),
    .group_id_o        (out_ch_o.group_id),
    .member_index_o    (out_ch_o.member_index),
    .target_handle_o   (out_ch_o.target_handle),
    .message_id_o      (out_ch_o.message_id),
    .message_ref_o     (out_ch_o.message_ref),
    .last_o            (out_ch_o.last)
  );

endmodule
`default_nettype wire
